[hw/rtl/nsfe_pkg.sv]
// ----------------------------------------------------------------------------
// nsfe_pkg
// Types, character codes and the field table of the NMEA field extractor.
// ----------------------------------------------------------------------------
package nsfe_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [2:0] clear_mask;
  } in_item_t;

  typedef struct packed {
    logic       store_valid;
    logic [3:0] field_id;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic [2:0] ready_flags;
    logic [2:0] altitude_length;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_DATA = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_GGA  = 2'd1,
    KIND_GSV  = 2'd2,
    KIND_RMC  = 2'd3
  } kind_t;

  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  localparam logic [39:0] NAME_GGA = "GPGGA";
  localparam logic [39:0] NAME_GSV = "GPGSV";
  localparam logic [39:0] NAME_RMC = "GPRMC";

  localparam int unsigned NAME_LEN = 5;
  localparam logic [7:0]  NAME_LAST = 8'd4;

  localparam logic [2:0] RDY_GGA = 3'b001;
  localparam logic [2:0] RDY_GSV = 3'b010;
  localparam logic [2:0] RDY_RMC = 3'b100;

  localparam logic [3:0] FLD_LAT       = 4'd0;
  localparam logic [3:0] FLD_LAT_HEMI  = 4'd1;
  localparam logic [3:0] FLD_LON       = 4'd2;
  localparam logic [3:0] FLD_LON_HEMI  = 4'd3;
  localparam logic [3:0] FLD_SATS_USED = 4'd4;
  localparam logic [3:0] FLD_ALTITUDE  = 4'd5;
  localparam logic [3:0] FLD_SATS_VIEW = 4'd6;
  localparam logic [3:0] FLD_TIME      = 4'd7;
  localparam logic [3:0] FLD_FIX       = 4'd8;
  localparam logic [3:0] FLD_SPEED     = 4'd9;
  localparam logic [3:0] FLD_COURSE    = 4'd10;
  localparam logic [3:0] FLD_DATE      = 4'd11;

  typedef struct packed {
    logic       hit;
    logic [3:0] len;
    logic [3:0] id;
  } field_rule_t;

  function automatic field_rule_t field_lookup(kind_t kind, logic [7:0] comma);
    field_rule_t r;
    r = '0;
    unique case (kind)
      KIND_GGA: begin
        unique case (comma)
          8'd2:    r = '{1'b1, 4'd9,  FLD_LAT};
          8'd3:    r = '{1'b1, 4'd1,  FLD_LAT_HEMI};
          8'd4:    r = '{1'b1, 4'd10, FLD_LON};
          8'd5:    r = '{1'b1, 4'd1,  FLD_LON_HEMI};
          8'd7:    r = '{1'b1, 4'd2,  FLD_SATS_USED};
          8'd9:    r = '{1'b1, 4'd6,  FLD_ALTITUDE};
          default: r = '0;
        endcase
      end
      KIND_GSV: begin
        unique case (comma)
          8'd3:    r = '{1'b1, 4'd2, FLD_SATS_VIEW};
          default: r = '0;
        endcase
      end
      KIND_RMC: begin
        unique case (comma)
          8'd1:    r = '{1'b1, 4'd6, FLD_TIME};
          8'd2:    r = '{1'b1, 4'd1, FLD_FIX};
          8'd7:    r = '{1'b1, 4'd5, FLD_SPEED};
          8'd8:    r = '{1'b1, 4'd5, FLD_COURSE};
          8'd9:    r = '{1'b1, 4'd6, FLD_DATE};
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/nsfe_parser.sv]
// ----------------------------------------------------------------------------
// nsfe_parser
// Sentence state and per-byte decode; result is combinational for the item
// accepted this cycle, state advances on accept.
// ----------------------------------------------------------------------------
module nsfe_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  nsfe_pkg::in_item_t  item,
  output nsfe_pkg::out_item_t result
);
  import nsfe_pkg::*;

  mode_t           mode_r, mode_nxt;
  kind_t           kind_r, kind_nxt;
  logic [7:0]      comma_r, comma_nxt;
  logic [7:0]      cc_r, cc_nxt;
  logic [4:0][7:0] name_r, name_nxt;
  logic [2:0]      alt_r, alt_nxt;
  logic [2:0]      ready_r, ready_nxt;

  field_rule_t     rule;
  logic [39:0]     name_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      kind_r  <= KIND_NONE;
      comma_r <= '0;
      cc_r    <= '0;
      name_r  <= '0;
      alt_r   <= '0;
      ready_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      kind_r  <= kind_nxt;
      comma_r <= comma_nxt;
      cc_r    <= cc_nxt;
      name_r  <= name_nxt;
      alt_r   <= alt_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign rule = field_lookup(kind_r, comma_r);

  always_comb begin
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    comma_nxt = comma_r;
    cc_nxt    = cc_r;
    name_nxt  = name_r;
    alt_nxt   = alt_r;
    ready_nxt = ready_r;
    name_word = '0;
    result    = '0;

    if (item.action == ACT_CLEAR) begin
      ready_nxt = ready_r & ~item.clear_mask;
    end else if (item.rx_byte == CH_DOLLAR) begin
      kind_nxt = KIND_NONE;
      mode_nxt = MODE_NAME;
      cc_nxt   = '0;
    end else if (item.rx_byte == CH_COMMA) begin
      comma_nxt = comma_r + 8'd1;
      cc_nxt    = '0;
    end else if (item.rx_byte == CH_STAR) begin
      unique case (kind_r)
        KIND_GGA: ready_nxt = ready_r | RDY_GGA;
        KIND_GSV: ready_nxt = ready_r | RDY_GSV;
        KIND_RMC: ready_nxt = ready_r | RDY_RMC;
        default:  ready_nxt = ready_r;
      endcase
      mode_nxt = MODE_IDLE;
    end else begin
      cc_nxt = cc_r + 8'd1;
      unique case (mode_r)
        MODE_NAME: begin
          if (cc_r < 8'(NAME_LEN)) begin
            name_nxt[cc_r[2:0]] = item.rx_byte;
          end
          name_word = {name_nxt[0], name_nxt[1], name_nxt[2], name_nxt[3], name_nxt[4]};
          if (cc_r >= NAME_LAST) begin
            if (name_word == NAME_GGA) begin
              kind_nxt  = KIND_GGA;
              alt_nxt   = '0;
            end else if (name_word == NAME_GSV) begin
              kind_nxt  = KIND_GSV;
            end else if (name_word == NAME_RMC) begin
              kind_nxt  = KIND_RMC;
            end
            if (name_word == NAME_GGA || name_word == NAME_GSV ||
                name_word == NAME_RMC) begin
              mode_nxt  = MODE_DATA;
              comma_nxt = '0;
              cc_nxt    = 8'd1;
            end
          end
        end
        MODE_DATA: begin
          if (rule.hit && cc_r < {4'd0, rule.len}) begin
            result.store_valid = 1'b1;
            result.field_id    = rule.id;
            result.char_index  = cc_r[3:0];
            result.char_value  = item.rx_byte;
            if (rule.id == FLD_ALTITUDE) begin
              alt_nxt = alt_r + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end

    result.ready_flags     = ready_nxt;
    result.altitude_length = alt_nxt;
  end

endmodule

[hw/rtl/nmea_sentence_field_extractor_top.sv]
// Each result item is registered (output register or skid) before it appears on out_*.
// Throughput: one item per cycle; a two-entry output stage (register plus skid)
//   keeps in_ready high while one result waits, so input stalls only when both are full.
// Reset: synchronous active-low rst_n clears the parser state (idle, no sentence,
//   counters, name buffer, ready flags) and empties the output stage.
// ----------------------------------------------------------------------------
// nmea_sentence_field_extractor_top
// NMEA byte stream parser emitting one tagged field store result per item.
// ----------------------------------------------------------------------------
module nmea_sentence_field_extractor_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nsfe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output nsfe_pkg::out_item_t out_item
);
  import nsfe_pkg::*;

  logic      in_acc, out_acc;
  out_item_t result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_item_r, skid_item_nxt;

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;

  nsfe_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_acc),
    .item   (in_item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (out_acc) begin
      if (skid_valid_r) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc;
        out_item_nxt  = result;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = in_acc;
      out_item_nxt  = result;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_item_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.store_valid) |->
      (out_item.field_id <= FLD_DATE && out_item.char_index <= 4'd9))
    else $error("store result outside field table");

  a_nostore_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.store_valid) |->
      (out_item.field_id == '0 && out_item.char_index == '0 && out_item.char_value == '0))
    else $error("no-store result carries nonzero fields");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");
`endif

endmodule
